### rtl/page_frame_allocator_core_assert.svh
// assertion macros used by the page frame allocator datapath
`ifndef PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define PFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define PFA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define PFA_ASSERT(lbl, prop, msg)
`define PFA_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

### rtl/pfa_pkg.sv
// shared constants, types and helpers of the page frame allocator
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int NUM_PAGES      = 192;
  localparam int RESERVED_PAGES = 48;
  localparam int BASE_ADDRESS   = 65536;

  localparam int RES_EFF    = (RESERVED_PAGES > NUM_PAGES) ? NUM_PAGES : RESERVED_PAGES;
  localparam int IDX_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int FREE_W     = $clog2(NUM_PAGES + 1);
  localparam int ADDR_W     = 20;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 8;
  localparam int FCOUNT_W   = 8;
  localparam int PAGE_SHIFT = 12;
  localparam int PGNUM_W    = ADDR_W - PAGE_SHIFT;

  localparam logic [COUNT_W-1:0] RESERVED_MARK = COUNT_W'(100);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_FREE      = 3'd1,
    ST_BELOW_BASE   = 3'd2,
    ST_NONEXISTENT  = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REL_ISSUE,
    S_REL_CHECK
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_GRANT,
    OP_DEC,
    OP_REPORT
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    rd;
    op_e     op;
    status_e code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic below;
    logic beyond;
    logic chk_vld;
    logic cnt_zero;
    logic chk_last;
    logic rd_done;
  } stat_t;

  // count of a page that has not been written since reset
  function automatic logic [COUNT_W-1:0] init_count(input logic [IDX_W-1:0] idx);
    logic [COUNT_W-1:0] res;
    res = (32'(idx) < RES_EFF) ? RESERVED_MARK : '0;
    return res;
  endfunction

endpackage

### rtl/pfa_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pfa_ctrl.sv
// controller state machine of the page frame allocator
`timescale 1ns / 1ps

module pfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          kind_i,
  input  pfa_pkg::stat_t stat_i,
  output pfa_pkg::cmd_t  cmd_o,
  output logic          busy
);

  import pfa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.rd   = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.code = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = kind_i ? S_REL_ISSUE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.chk_vld && stat_i.cnt_zero) begin
          cmd_o.op = OP_GRANT;
          state_d  = S_IDLE;
        end else if (stat_i.chk_vld && stat_i.chk_last) begin
          cmd_o.op   = OP_REPORT;
          cmd_o.code = ST_NO_FREE;
          state_d    = S_IDLE;
        end else begin
          cmd_o.rd = !stat_i.rd_done;
        end
      end
      S_REL_ISSUE: begin
        if (stat_i.below) begin
          cmd_o.op   = OP_REPORT;
          cmd_o.code = ST_BELOW_BASE;
          state_d    = S_IDLE;
        end else if (stat_i.beyond) begin
          cmd_o.op   = OP_REPORT;
          cmd_o.code = ST_NONEXISTENT;
          state_d    = S_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_REL_CHECK;
        end
      end
      S_REL_CHECK: begin
        if (stat_i.cnt_zero) begin
          cmd_o.op   = OP_REPORT;
          cmd_o.code = ST_ALREADY_FREE;
        end else begin
          cmd_o.op = OP_DEC;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

### rtl/pfa_dpath.sv
// datapath of the page frame allocator: count map, scan pointer, free count, result
`timescale 1ns / 1ps

`include "page_frame_allocator_core_assert.svh"

module pfa_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfa_pkg::cmd_t                 cmd_i,
  input  logic                          kind_i,
  input  logic [pfa_pkg::ADDR_W-1:0]    page_address_i,
  output pfa_pkg::stat_t                stat_o,
  output logic                          result_strobe_o,
  output logic [pfa_pkg::ADDR_W-1:0]    granted_address_o,
  output logic [pfa_pkg::STATUS_W-1:0]  status_o,
  output logic [pfa_pkg::FCOUNT_W-1:0]  free_count_o
);

  import pfa_pkg::*;

  // address decode of the incoming transaction
  logic                  below;
  logic [ADDR_W-1:0]     offset;
  logic [PGNUM_W-1:0]    page_raw;
  logic                  beyond;

  assign below    = ({1'b0, page_address_i} < 21'(BASE_ADDRESS));
  assign offset   = ADDR_W'(32'(page_address_i) - 32'(BASE_ADDRESS));
  assign page_raw = offset[ADDR_W-1:PAGE_SHIFT];
  assign beyond   = (32'(page_raw) >= NUM_PAGES);

  logic                  below_q, beyond_q;
  logic [IDX_W-1:0]      scan_q;
  logic                  rd_done_q;
  logic                  chk_vld_q;
  logic [IDX_W-1:0]      chk_idx_q;
  logic                  vld_rd_q;
  logic [NUM_PAGES-1:0]  valid_q;
  logic [FREE_W-1:0]     free_q;
  logic                  strobe_q;
  logic [ADDR_W-1:0]     granted_q;
  status_e               status_q;

  // count map
  logic                  ram_we;
  logic [COUNT_W-1:0]    ram_wdata;
  logic [COUNT_W-1:0]    ram_rdata;
  logic [COUNT_W-1:0]    eff_cnt;
  logic [ADDR_W-1:0]     grant_addr;

  assign eff_cnt    = vld_rd_q ? ram_rdata : init_count(chk_idx_q);
  assign ram_we     = (cmd_i.op == OP_GRANT) || (cmd_i.op == OP_DEC);
  assign ram_wdata  = (cmd_i.op == OP_GRANT) ? COUNT_W'(1) : (eff_cnt - COUNT_W'(1));
  assign grant_addr = ADDR_W'((32'(chk_idx_q) << PAGE_SHIFT) + 32'(BASE_ADDRESS));

  pfa_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_PAGES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (chk_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  // transaction latch and scan pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_done_q <= 1'b0;
      chk_vld_q <= 1'b0;
    end else begin
      chk_vld_q <= cmd_i.rd;
      if (cmd_i.load) begin
        rd_done_q <= 1'b0;
      end else if (cmd_i.rd && (scan_q == '0)) begin
        rd_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      below_q  <= below;
      beyond_q <= beyond;
      scan_q   <= kind_i ? IDX_W'(page_raw) : IDX_W'(NUM_PAGES - 1);
    end else if (cmd_i.rd && (scan_q != '0)) begin
      scan_q <= scan_q - IDX_W'(1);
    end
    if (cmd_i.rd) begin
      chk_idx_q <= scan_q;
      vld_rd_q  <= valid_q[scan_q];
    end
  end

  // valid bits and free count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      free_q  <= FREE_W'(NUM_PAGES - RES_EFF);
    end else begin
      if (ram_we) begin
        valid_q[chk_idx_q] <= 1'b1;
      end
      if ((cmd_i.op == OP_GRANT) && (free_q != '0)) begin
        free_q <= free_q - FREE_W'(1);
      end else if ((cmd_i.op == OP_DEC) && (eff_cnt == COUNT_W'(1))) begin
        free_q <= free_q + FREE_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (cmd_i.op != OP_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op != OP_NONE) begin
      granted_q <= (cmd_i.op == OP_GRANT) ? grant_addr : '0;
      status_q  <= (cmd_i.op == OP_REPORT) ? cmd_i.code : ST_OK;
    end
  end

  assign stat_o.below    = below_q;
  assign stat_o.beyond   = beyond_q;
  assign stat_o.chk_vld  = chk_vld_q;
  assign stat_o.cnt_zero = (eff_cnt == '0);
  assign stat_o.chk_last = (chk_idx_q == '0);
  assign stat_o.rd_done  = rd_done_q;

  assign result_strobe_o   = strobe_q;
  assign granted_address_o = granted_q;
  assign status_o          = status_q;
  assign free_count_o      = FCOUNT_W'(free_q);

  `PFA_ASSERT_NEVER(a_free_range, 32'(free_q) > NUM_PAGES, "free count above page count")
  `PFA_ASSERT(a_no_free_empty, (strobe_q && (status_q == ST_NO_FREE)) |-> (free_q == '0), "no free page reported while pages are free")
  `PFA_ASSERT(a_grant_zero, (cmd_i.op == OP_GRANT) |-> (chk_vld_q && (eff_cnt == '0)), "grant of a page in use")
  `PFA_ASSERT(a_strobe_single, strobe_q |=> !strobe_q, "result strobe longer than one cycle")

endmodule

### rtl/page_frame_allocator_core.sv
// top level of the page frame allocator
`timescale 1ns / 1ps

// page frame allocator over a per-page use-count map
//
// usage: drive kind_i (0 allocate, 1 release) and page_address_i with start
// high; the transaction is taken at the rising edge where start is high and
// busy is low. busy stays high until the result is formed. each transaction
// gives exactly one result on granted_address_o, status_o and free_count_o,
// valid for the single cycle in which result_strobe_o is high; the receiver
// cannot stall, so it must take the result in that cycle.
//
// sequence: a release makes one count map read before its result, or none
// when the address is below the base or past the last page. an allocate
// scans the map from the top page down, one page per cycle through the
// registered read port of the map ram, and stops at the first free page or
// after the bottom page when no page is free. a new transaction may be
// started in the strobe cycle of the previous one.
//
// reset: all control state clears at once; the count map itself is not
// cleared, per-page valid bits mark never-written entries, which read as
// 100 for reserved pages and 0 otherwise, so the block is usable right away.

module page_frame_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [pfa_pkg::ADDR_W-1:0]    page_address_i,
  output logic                          result_strobe_o,
  output logic [pfa_pkg::ADDR_W-1:0]    granted_address_o,
  output logic [pfa_pkg::STATUS_W-1:0]  status_o,
  output logic [pfa_pkg::FCOUNT_W-1:0]  free_count_o
);

  import pfa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing: accept, scan or release check, commit
  pfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // count map, free count and result register
  pfa_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .kind_i            (kind_i),
    .page_address_i    (page_address_i),
    .stat_o            (stat),
    .result_strobe_o   (result_strobe_o),
    .granted_address_o (granted_address_o),
    .status_o          (status_o),
    .free_count_o      (free_count_o)
  );

endmodule
